// ----- rtl/core/image_header_dimension_extractor_core_defines.svh -----
// assertion macros for the image header dimension extractor core
// taken in by the top level, which checks its own logic; no other dependencies
`ifndef IMAGE_HEADER_DIMENSION_EXTRACTOR_CORE_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_EXTRACTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define IHDE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define IHDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IHDE_ASSERT(lbl, clk, rstn, prop, msg)
`define IHDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/core/ihde_pkg.sv -----
// shared types and constants for the image header dimension extractor core
// no dependencies; used by the parser, the result register and the top level
`timescale 1ns / 1ps

package ihde_pkg;

    // image format codes of the configuration register
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_JPEG = 3'd1;
    localparam logic [2:0] FMT_PNG  = 3'd2;
    localparam logic [2:0] FMT_GIF  = 3'd3;
    localparam logic [2:0] FMT_BMP  = 3'd4;

    // byte position saturates here
    localparam logic [4:0] POS_MAX = 5'd31;

    // jpeg marker window
    localparam int unsigned WIN_LEN = 9;
    localparam logic [4:0] WIN_COUNT = 5'd9;
    localparam logic [7:0] JPEG_MARK = 8'hFF;
    localparam logic [7:0] JPEG_SOF0 = 8'hC0;

    // minimum byte counts
    localparam logic [4:0] MIN_COUNT = 5'd16;
    localparam logic [4:0] PNG_MIN   = 5'd24;
    localparam logic [4:0] BMP_MIN   = 5'd26;

    // signatures
    localparam logic [7:0] PNG_SIG [4] = '{8'h89, 8'h50, 8'h4E, 8'h47};
    localparam logic [7:0] GIF_SIG [6] = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61};
    localparam logic [7:0] GIF_ALT_VER = 8'h39;
    localparam logic [7:0] BMP_SIG [2] = '{8'h42, 8'h4D};

    // one result item
    typedef struct packed {
        logic        depth_valid;
        logic [15:0] pixel_depth;
        logic [31:0] height;
        logic [31:0] width;
        logic        found;
    } result_t;

endpackage

// ----- rtl/core/image_header_dimension_extractor_core.sv -----
// top level of the image header dimension extractor: input register, parser, result register
// depends on ihde_pkg, ihde_hdr_parse, ihde_out_reg and the assertion macro header
//
//  channel   dir  tdata                                    tuser / tlast
//  s_axis    in   [7:0] data_byte                          tlast: last_byte
//  m_axis    out  [31:0] width [63:32] height [79:64] depth tuser: [0] found [1] depth_valid
//  cfg       in   cfg_wdata[2:0] image_format              write on cfg_we
//
// one byte per cycle sustained while no last byte waits; each byte passes through the input
// register, and the edge that moves a last byte out of it loads its result into the result
// register, which drives m_axis
// bytes without tlast keep flowing while a result waits; a last byte waits in the
// input register until the result register is free
// rst_n clears the stream state and sets the format to none
`timescale 1ns / 1ps
`include "image_header_dimension_extractor_core_defines.svh"

module image_header_dimension_extractor_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,     // image_format
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // [31:0] width, [63:32] height, [79:64] pixel_depth
    output logic [1:0]  m_axis_tuser   // [0] found, [1] depth_valid
);

    logic [2:0]        image_format_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              s_accept;
    logic              advance;
    logic              out_free;
    ihde_pkg::result_t parse_result;
    ihde_pkg::result_t out_result;

    // format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_format_reg <= ihde_pkg::FMT_NONE;
        end
        else if (cfg_we)
        begin
            image_format_reg <= cfg_wdata;
        end
    end

    // input register handshake
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // header parser
    ihde_hdr_parse u_parse
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_format (image_format_reg),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .result       (parse_result)
    );

    // result register
    ihde_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && in_last_reg),
        .result_in  (parse_result),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .result_out (out_result),
        .free       (out_free)
    );

    // master side packing
    assign m_axis_tdata = {out_result.pixel_depth, out_result.height, out_result.width};
    assign m_axis_tuser = {out_result.depth_valid, out_result.found};

    // a last byte that meets a free result register shows up in the next cycle
    `IHDE_ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_valid_reg && in_last_reg && !m_axis_tvalid, m_axis_tvalid, "last byte did not produce a result")
    // no match means all fields are zero
    `IHDE_ASSERT(a_miss_zero, clk, rst_n, !(m_axis_tvalid && !m_axis_tuser[0]) || (m_axis_tdata == 80'd0 && !m_axis_tuser[1]), "unmatched result carries nonzero fields")
    // depth is only reported together with a match
    `IHDE_ASSERT(a_depth_needs_found, clk, rst_n, !(m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0]), "depth_valid without found")
    // input side only stalls with a last byte waiting in the input register and a result pending
    `IHDE_ASSERT(a_stall_only_full, clk, rst_n, s_axis_tready || (in_valid_reg && in_last_reg && m_axis_tvalid), "input stalled without a waiting last byte")

endmodule

// ----- rtl/core/ihde_hdr_parse.sv -----
// per-byte header parser: stream state, signature check, field capture
// depends on ihde_pkg
`timescale 1ns / 1ps

module ihde_hdr_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           image_format,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output ihde_pkg::result_t    result
);

    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [7:0]  recent_reg [ihde_pkg::WIN_LEN];
    logic [7:0]  recent_next [ihde_pkg::WIN_LEN];
    logic        sig_ok_reg;
    logic        sig_ok_next;
    logic [31:0] width_reg;
    logic [31:0] width_next;
    logic [31:0] height_reg;
    logic [31:0] height_next;
    logic [15:0] depth_reg;
    logic [15:0] depth_next;
    logic        match_reg;
    logic        match_next;
    logic        known_reg;
    logic        known_next;
    logic [1:0]  lane_w;
    logic [1:0]  lane_h;
    logic        found;
    logic        dvalid;

    // window shift, signature check and field capture for one byte
    always_comb
    begin
        pos_next    = pos_reg;
        sig_ok_next = sig_ok_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        match_next  = match_reg;
        known_next  = known_reg;
        lane_w      = 2'(pos_reg - 5'd18);
        lane_h      = 2'(pos_reg - 5'd22);
        for (int i = 0; i < ihde_pkg::WIN_LEN - 1; i++)
        begin
            recent_next[i] = recent_reg[i + 1];
        end
        recent_next[ihde_pkg::WIN_LEN - 1] = data_byte;

        if (pos_reg != ihde_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 5'd1;
            case (image_format)
                ihde_pkg::FMT_PNG:
                begin
                    if (pos_reg < 5'd4 && data_byte != ihde_pkg::PNG_SIG[pos_reg[1:0]])
                    begin
                        sig_ok_next = 1'b0;
                    end
                    if (pos_reg inside {[5'd16:5'd19]})
                    begin
                        width_next = {width_reg[23:0], data_byte};
                    end
                    else if (pos_reg inside {[5'd20:5'd23]})
                    begin
                        height_next = {height_reg[23:0], data_byte};
                    end
                    else if (pos_reg == 5'd24)
                    begin
                        depth_next = {8'd0, data_byte};
                        known_next = 1'b1;
                    end
                end
                ihde_pkg::FMT_GIF:
                begin
                    if (pos_reg < 5'd6 && data_byte != ihde_pkg::GIF_SIG[pos_reg[2:0]] &&
                        !(pos_reg == 5'd4 && data_byte == ihde_pkg::GIF_ALT_VER))
                    begin
                        sig_ok_next = 1'b0;
                    end
                    if (pos_reg == 5'd6)
                    begin
                        width_next = width_reg | {24'd0, data_byte};
                    end
                    else if (pos_reg == 5'd7)
                    begin
                        width_next = width_reg | {16'd0, data_byte, 8'd0};
                    end
                    else if (pos_reg == 5'd8)
                    begin
                        height_next = height_reg | {24'd0, data_byte};
                    end
                    else if (pos_reg == 5'd9)
                    begin
                        height_next = height_reg | {16'd0, data_byte, 8'd0};
                    end
                    else if (pos_reg == 5'd10 && data_byte[7])
                    begin
                        // global color table present: depth from its size field
                        depth_next = {13'd0, data_byte[2:0]} + 16'd1;
                        known_next = 1'b1;
                    end
                end
                ihde_pkg::FMT_BMP:
                begin
                    if (pos_reg < 5'd2 && data_byte != ihde_pkg::BMP_SIG[pos_reg[0]])
                    begin
                        sig_ok_next = 1'b0;
                    end
                    if (pos_reg inside {[5'd18:5'd21]})
                    begin
                        width_next = width_reg | ({24'd0, data_byte} << {lane_w, 3'b000});
                    end
                    else if (pos_reg inside {[5'd22:5'd25]})
                    begin
                        height_next = height_reg | ({24'd0, data_byte} << {lane_h, 3'b000});
                    end
                    else if (pos_reg == 5'd28)
                    begin
                        depth_next = {8'd0, data_byte};
                    end
                    else if (pos_reg == 5'd29)
                    begin
                        depth_next = depth_reg | {data_byte, 8'd0};
                        known_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // first start-of-frame window in a jpeg stream
        if (image_format == ihde_pkg::FMT_JPEG && !match_reg &&
            pos_next >= ihde_pkg::WIN_COUNT &&
            recent_next[0] == ihde_pkg::JPEG_MARK && recent_next[1] == ihde_pkg::JPEG_SOF0)
        begin
            height_next = {16'd0, recent_next[5], recent_next[6]};
            width_next  = {16'd0, recent_next[7], recent_next[8]};
            depth_next  = {5'd0, recent_next[4], 3'b000};
            known_next  = 1'b1;
            match_next  = 1'b1;
        end
    end

    // result decision on the last byte
    always_comb
    begin
        found = 1'b0;
        if (pos_next >= ihde_pkg::MIN_COUNT)
        begin
            case (image_format)
                ihde_pkg::FMT_JPEG: found = match_next;
                ihde_pkg::FMT_PNG:  found = sig_ok_next && pos_next >= ihde_pkg::PNG_MIN;
                ihde_pkg::FMT_GIF:  found = sig_ok_next;
                ihde_pkg::FMT_BMP:  found = sig_ok_next && pos_next >= ihde_pkg::BMP_MIN;
                default:            found = 1'b0;
            endcase
        end
        dvalid              = found && known_next;
        result.found        = found;
        result.width        = found ? width_next : 32'd0;
        result.height       = found ? height_next : 32'd0;
        result.pixel_depth  = dvalid ? depth_next : 16'd0;
        result.depth_valid  = dvalid;
    end

    // stream state, cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sig_ok_reg <= 1'b1;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            match_reg  <= 1'b0;
            known_reg  <= 1'b0;
            for (int i = 0; i < ihde_pkg::WIN_LEN; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                sig_ok_reg <= 1'b1;
                width_reg  <= '0;
                height_reg <= '0;
                depth_reg  <= '0;
                match_reg  <= 1'b0;
                known_reg  <= 1'b0;
                for (int i = 0; i < ihde_pkg::WIN_LEN; i++)
                begin
                    recent_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg    <= pos_next;
                sig_ok_reg <= sig_ok_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                depth_reg  <= depth_next;
                match_reg  <= match_next;
                known_reg  <= known_next;
                for (int i = 0; i < ihde_pkg::WIN_LEN; i++)
                begin
                    recent_reg[i] <= recent_next[i];
                end
            end
        end
    end

endmodule

// ----- rtl/core/ihde_out_reg.sv -----
// result register on the master side, holds a result until its transfer
// depends on ihde_pkg
`timescale 1ns / 1ps

module ihde_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ihde_pkg::result_t    result_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output ihde_pkg::result_t    result_out,
    output logic                 free
);

    logic              valid_reg;
    logic              valid_next;
    ihde_pkg::result_t data_reg;

    // slot can take a new result when empty or draining this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

// ----- tb/tb_image_header_dimension_extractor_core.sv -----
// testbench for image_header_dimension_extractor_core: jpeg, png, gif and bmp byte streams
// with predicted dimensions checked on every m_axis transfer, under several idle patterns
// depends on ihde_pkg and the core rtl
`timescale 1ns / 1ps

module tb_image_header_dimension_extractor_core;

    // format codes the core does not decode
    localparam logic [2:0] FMT_RSVD5 = 3'd5;
    localparam logic [2:0] FMT_RSVD6 = 3'd6;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;
    localparam logic [2:0] FMT_UNKNOWN [4] =
        '{ihde_pkg::FMT_NONE, FMT_RSVD5, FMT_RSVD6, FMT_RSVD7};
    localparam logic [2:0] FMT_KINDS [5] = '{ihde_pkg::FMT_NONE, ihde_pkg::FMT_JPEG,
        ihde_pkg::FMT_PNG, ihde_pkg::FMT_GIF, ihde_pkg::FMT_BMP};

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 500;
    localparam int RANDOM_PHASES = 4;

    // per-image header predictor and queue of expected dimension results
    class header_dims_scoreboard;
        logic [2:0]  fmt;
        logic [4:0]  pos;
        logic [7:0]  win [ihde_pkg::WIN_LEN];
        bit          sig_ok;
        logic [31:0] width_acc;
        logic [31:0] height_acc;
        logic [15:0] depth_acc;
        bit          sof_seen;
        bit          depth_seen;
        ihde_pkg::result_t expected_dims [$];
        int          mismatches;

        function new();
            fmt = ihde_pkg::FMT_NONE;
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            pos = '0;
            foreach (win[i]) win[i] = '0;
            sig_ok = 1'b1;
            width_acc = '0;
            height_acc = '0;
            depth_acc = '0;
            sof_seen = 1'b0;
            depth_seen = 1'b0;
        endfunction

        function void set_format(logic [2:0] v);
            fmt = v;
        endfunction

        // one accepted byte; an image's last byte queues its result
        function void take_byte(logic [7:0] b, logic last);
            logic [4:0] p;
            bit         found;
            bit         dvalid;
            ihde_pkg::result_t r;
            for (int i = 0; i < ihde_pkg::WIN_LEN - 1; i++) win[i] = win[i + 1];
            win[ihde_pkg::WIN_LEN - 1] = b;
            p = pos;
            // signature check and field capture at fixed offsets
            if (p < ihde_pkg::POS_MAX) begin
                case (fmt)
                    ihde_pkg::FMT_PNG:
                    begin
                        if (p < 4 && b != ihde_pkg::PNG_SIG[p[1:0]]) sig_ok = 1'b0;
                        if (p >= 16 && p <= 19) width_acc = {width_acc[23:0], b};
                        else if (p >= 20 && p <= 23) height_acc = {height_acc[23:0], b};
                        else if (p == 24)
                        begin
                            depth_acc = {8'h00, b};
                            depth_seen = 1'b1;
                        end
                    end
                    ihde_pkg::FMT_GIF:
                    begin
                        if (p < 6 && b != ihde_pkg::GIF_SIG[p[2:0]] &&
                            !(p == 4 && b == ihde_pkg::GIF_ALT_VER))
                            sig_ok = 1'b0;
                        if (p == 6 || p == 7) width_acc |= 32'(b) << (8 * (p - 6));
                        else if (p == 8 || p == 9) height_acc |= 32'(b) << (8 * (p - 8));
                        else if (p == 10 && b[7])
                        begin
                            depth_acc = 16'(b[2:0]) + 16'd1;
                            depth_seen = 1'b1;
                        end
                    end
                    ihde_pkg::FMT_BMP:
                    begin
                        if (p < 2 && b != ihde_pkg::BMP_SIG[p[0]]) sig_ok = 1'b0;
                        if (p >= 18 && p <= 21) width_acc |= 32'(b) << (8 * (p - 18));
                        else if (p >= 22 && p <= 25) height_acc |= 32'(b) << (8 * (p - 22));
                        else if (p == 28) depth_acc = {8'h00, b};
                        else if (p == 29)
                        begin
                            depth_acc |= {b, 8'h00};
                            depth_seen = 1'b1;
                        end
                    end
                    default: ;
                endcase
                pos = p + 5'd1;
            end
            // first start-of-frame window wins
            if (fmt == ihde_pkg::FMT_JPEG && !sof_seen && pos >= ihde_pkg::WIN_COUNT &&
                win[0] == ihde_pkg::JPEG_MARK && win[1] == ihde_pkg::JPEG_SOF0)
            begin
                height_acc = {16'h0000, win[5], win[6]};
                width_acc = {16'h0000, win[7], win[8]};
                depth_acc = {5'b00000, win[4], 3'b000};
                depth_seen = 1'b1;
                sof_seen = 1'b1;
            end
            if (last)
            begin
                found = 1'b0;
                dvalid = 1'b0;
                if (pos >= ihde_pkg::MIN_COUNT)
                begin
                    case (fmt)
                        ihde_pkg::FMT_JPEG: found = sof_seen;
                        ihde_pkg::FMT_PNG:  found = sig_ok && pos >= ihde_pkg::PNG_MIN;
                        ihde_pkg::FMT_GIF:  found = sig_ok;
                        ihde_pkg::FMT_BMP:  found = sig_ok && pos >= ihde_pkg::BMP_MIN;
                        default:            found = 1'b0;
                    endcase
                    dvalid = found && depth_seen;
                end
                r.found = found;
                r.width = found ? width_acc : '0;
                r.height = found ? height_acc : '0;
                r.pixel_depth = dvalid ? depth_acc : '0;
                r.depth_valid = dvalid;
                expected_dims.push_back(r);
                clear_stream();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // one result transfer against the oldest pending image
        task check_dims(logic [79:0] data, logic [1:0] user);
            ihde_pkg::result_t want;
            if (expected_dims.size() == 0)
            begin
                report("result transfer with no image pending");
            end
            else
            begin
                want = expected_dims.pop_front();
                check_field("found", 32'(user[0]), 32'(want.found));
                check_field("width", data[31:0], want.width);
                check_field("height", data[63:32], want.height);
                check_field("pixel_depth", 32'(data[79:64]), 32'(want.pixel_depth));
                check_field("depth_valid", 32'(user[1]), 32'(want.depth_valid));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = ihde_pkg::FMT_NONE;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    header_dims_scoreboard sb;
    logic [7:0] img [$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_active = 1'b0;
    int         cycles = 0;
    int         bytes_sent = 0;
    int         images_sent = 0;

    image_header_dimension_extractor_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_image_header_dimension_extractor_core failed");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready) sb.check_dims(m_axis_tdata, m_axis_tuser);
            if (hold_active) m_axis_tready <= 1'b0;
            else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function void put(int idx, logic [7:0] v);
        if (idx < img.size()) img[idx] = v;
    endfunction

    function logic [31:0] rand_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.take_byte(b, last);
        bytes_sent++;
        if (last) images_sent++;
    endtask

    // random bytes with a header of the given kind laid over them
    task automatic build_image(logic [2:0] kind, int len, bit corrupt,
                               logic [31:0] w, logic [31:0] h, logic [15:0] d);
        int m;
        img.delete();
        for (int i = 0; i < len; i++) img.push_back(8'($urandom));
        case (kind)
            ihde_pkg::FMT_JPEG:
            begin
                if (!corrupt && len >= ihde_pkg::WIN_LEN)
                begin
                    m = $urandom_range(len - ihde_pkg::WIN_LEN);
                    put(m, ihde_pkg::JPEG_MARK);
                    put(m + 1, ihde_pkg::JPEG_SOF0);
                    put(m + 4, d[7:0]);
                    put(m + 5, h[15:8]);
                    put(m + 6, h[7:0]);
                    put(m + 7, w[15:8]);
                    put(m + 8, w[7:0]);
                end
            end
            ihde_pkg::FMT_PNG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    put(i, ihde_pkg::PNG_SIG[i]);
                    put(16 + i, w[31 - 8 * i -: 8]);
                    put(20 + i, h[31 - 8 * i -: 8]);
                end
                put(24, d[7:0]);
                if (corrupt)
                begin
                    m = $urandom_range(3);
                    put(m, ihde_pkg::PNG_SIG[m] ^ 8'($urandom_range(255, 1)));
                end
            end
            ihde_pkg::FMT_GIF:
            begin
                for (int i = 0; i < 6; i++) put(i, ihde_pkg::GIF_SIG[i]);
                if ($urandom_range(1)) put(4, ihde_pkg::GIF_ALT_VER);
                put(6, w[7:0]);
                put(7, w[15:8]);
                put(8, h[7:0]);
                put(9, h[15:8]);
                put(10, d[7:0]);
                if (corrupt)
                begin
                    m = $urandom_range(5);
                    put(m, ihde_pkg::GIF_SIG[m] ^ 8'($urandom_range(255, 1)));
                end
            end
            ihde_pkg::FMT_BMP:
            begin
                put(0, ihde_pkg::BMP_SIG[0]);
                put(1, ihde_pkg::BMP_SIG[1]);
                for (int i = 0; i < 4; i++)
                begin
                    put(18 + i, w[8 * i +: 8]);
                    put(22 + i, h[8 * i +: 8]);
                end
                put(28, d[7:0]);
                put(29, d[15:8]);
                if (corrupt)
                begin
                    m = $urandom_range(1);
                    put(m, ihde_pkg::BMP_SIG[m] ^ 8'($urandom_range(255, 1)));
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_image(logic [2:0] kind, int len, bit corrupt,
                              logic [31:0] w, logic [31:0] h, logic [15:0] d);
        build_image(kind, len, corrupt, w, h, d);
        for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
    endtask

    // mostly header-sized images, some short, some past the saturation point
    task automatic rand_image(logic [2:0] kind);
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(34, 16);
        else if (r < 85) len = $urandom_range(15, 1);
        else len = $urandom_range(64, 35);
        push_image(kind, len, $urandom_range(99) < 15, rand_word(), rand_word(),
                   16'($urandom));
    endtask

    // wait for all results, then for the input register to empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_dims.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(logic [2:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_format(v);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0:
            begin
                send_idle_pct <= 0;
                recv_stall_pct <= 0;
            end
            1:
            begin
                send_idle_pct <= 62;
                recv_stall_pct <= 0;
            end
            2:
            begin
                send_idle_pct <= 0;
                recv_stall_pct <= 62;
            end
            default:
            begin
                send_idle_pct <= 14;
                recv_stall_pct <= 14;
            end
        endcase
    endtask

    initial
    begin
        int          start_bytes;
        int          phases;
        int          mode;
        logic [2:0]  fmt;
        logic [2:0]  kind;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no format selected
        write_format(ihde_pkg::FMT_NONE);
        push_image(ihde_pkg::FMT_PNG, 30, 0, 32'h0000_0100, 32'h0000_0080, 16'h0008);
        settle();

        // directed: jpeg extremes, short, no marker, long stream, one-byte images
        write_format(ihde_pkg::FMT_JPEG);
        push_image(ihde_pkg::FMT_JPEG, 20, 0, 32'hFFFF, 32'hFFFF, 16'h00FF);
        push_image(ihde_pkg::FMT_JPEG, 20, 0, 32'h0, 32'h0, 16'h0000);
        push_image(ihde_pkg::FMT_JPEG, 12, 0, 32'h1234, 32'h5678, 16'h0003);
        push_image(ihde_pkg::FMT_JPEG, 24, 1, 32'h1234, 32'h5678, 16'h0003);
        push_image(ihde_pkg::FMT_JPEG, 64, 0, 32'h0280, 32'h01E0, 16'h0001);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        settle();

        // directed: png full, exactly 24, 23, 25 bytes, bad signature
        write_format(ihde_pkg::FMT_PNG);
        push_image(ihde_pkg::FMT_PNG, 30, 0, 32'hFFFF_FFFF, 32'h0, 16'h00FF);
        push_image(ihde_pkg::FMT_PNG, 24, 0, 32'h0000_0400, 32'h0000_0300, 16'h0008);
        push_image(ihde_pkg::FMT_PNG, 23, 0, 32'h0000_0400, 32'h0000_0300, 16'h0008);
        push_image(ihde_pkg::FMT_PNG, 25, 0, 32'h0000_0001, 32'h0000_0001, 16'h0010);
        push_image(ihde_pkg::FMT_PNG, 30, 1, 32'h0000_0400, 32'h0000_0300, 16'h0008);
        settle();

        // directed: gif with and without color table flag, bad signature, short
        write_format(ihde_pkg::FMT_GIF);
        push_image(ihde_pkg::FMT_GIF, 16, 0, 32'hFFFF, 32'hFFFF, 16'h00FF);
        push_image(ihde_pkg::FMT_GIF, 16, 0, 32'h0, 32'h0, 16'h007F);
        push_image(ihde_pkg::FMT_GIF, 20, 1, 32'h0140, 32'h00C8, 16'h0080);
        push_image(ihde_pkg::FMT_GIF, 11, 0, 32'h0140, 32'h00C8, 16'h0087);
        settle();

        // directed: bmp depth present, depth cut off, minimum, too short, bad, long
        write_format(ihde_pkg::FMT_BMP);
        push_image(ihde_pkg::FMT_BMP, 30, 0, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
        push_image(ihde_pkg::FMT_BMP, 29, 0, 32'h0000_0200, 32'h0000_0100, 16'h0018);
        push_image(ihde_pkg::FMT_BMP, 26, 0, 32'h0000_0200, 32'h0000_0100, 16'h0018);
        push_image(ihde_pkg::FMT_BMP, 25, 0, 32'h0000_0200, 32'h0000_0100, 16'h0018);
        push_image(ihde_pkg::FMT_BMP, 30, 1, 32'h0000_0200, 32'h0000_0100, 16'h0018);
        push_image(ihde_pkg::FMT_BMP, 64, 0, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0020);
        settle();

        // directed: undecoded format codes
        write_format(FMT_RSVD5);
        push_image(ihde_pkg::FMT_PNG, 30, 0, 32'h10, 32'h10, 16'h08);
        settle();
        write_format(FMT_RSVD6);
        push_image(ihde_pkg::FMT_BMP, 30, 0, 32'h10, 32'h10, 16'h08);
        settle();
        write_format(FMT_RSVD7);
        push_image(ihde_pkg::FMT_GIF, 20, 0, 32'h10, 32'h10, 16'h88);
        settle();

        // directed: format switched partway through an image
        write_format(ihde_pkg::FMT_PNG);
        build_image(ihde_pkg::FMT_PNG, 32, 0, 32'h0000_0640, 32'h0000_04B0, 16'h0008);
        for (int i = 0; i < 8; i++) send_byte(img[i], 1'b0);
        settle();
        write_format(ihde_pkg::FMT_BMP);
        for (int i = 8; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
        settle();

        // long receiver hold-off while the sender keeps offering random images
        write_format(ihde_pkg::FMT_GIF);
        fork
        begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
        join_none
        for (int i = 0; i < 10; i++) rand_image(ihde_pkg::FMT_GIF);
        settle();

        // random phases, each with its own format and idle pattern
        start_bytes = bytes_sent;
        phases = 0;
        mode = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES || phases < RANDOM_PHASES)
        begin
            set_idle(mode);
            mode = (mode + 1) % 4;
            phases++;
            if ($urandom_range(99) < 85) fmt = FMT_KINDS[$urandom_range(4, 1)];
            else fmt = FMT_UNKNOWN[$urandom_range(3)];
            write_format(fmt);
            repeat ($urandom_range(5, 3))
            begin
                if ($urandom_range(99) < 80 && fmt != ihde_pkg::FMT_NONE && fmt < FMT_RSVD5)
                    kind = fmt;
                else kind = FMT_KINDS[$urandom_range(4)];
                rand_image(kind);
            end
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_image_header_dimension_extractor_core passed");
        else
            $display("tb_image_header_dimension_extractor_core failed");
        $finish;
    end

endmodule
